/* design/sfdc_pkg.sv */
// ---------------------------------------------------------------------------
// sfdc_pkg
// Shared types and constants of the serial frame deframer and checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfdc_pkg;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_HDR_SUM    = 3'd1,
		ST_BUF_SHORT  = 3'd2,
		ST_TRAILER    = 3'd3,
		ST_MSG_SYNC   = 3'd4,
		ST_LEN_MISM   = 3'd5,
		ST_NO_SYNC    = 3'd6
	} status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_FRAME_SYNC_HIGH = 2'd0,
		REG_FRAME_SYNC_LOW  = 2'd1,
		REG_MSG_SYNC_HIGH   = 2'd2,
		REG_MSG_SYNC_LOW    = 2'd3
	} reg_index_t;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;

	// shortest frame that holds the full message header
	localparam logic [WORD_W-1:0] MIN_FRAME_LEN = 16'd11;
	// frame length minus message length
	localparam logic [WORD_W-1:0] MSG_LEN_OFFSET = 16'd6;

endpackage

`default_nettype wire

/* design/serial_frame_deframer_checker.sv */
// A status caused by a byte accepted at a clock edge is registered at that edge
// and is valid at the output just after it.
// Throughput: one byte per cycle; the input stalls only while the output
// register holds a status that the receiver stalls.
// Reset: arst_n clears parse state, configuration and the output register
// asynchronously; the parser starts out hunting for the frame sync.
// ---------------------------------------------------------------------------
// serial_frame_deframer_checker
// Hunts for a frame sync, checks the header sum, frame length, trailer checksum,
// message sync and message length; one status per frame, or no sync at chunk end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_wr_en,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [sfdc_pkg::BYTE_W-1:0]   cfg_data,
	// byte input
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sfdc_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                          buffer_last,
	// status output
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [2:0]                         status,
	output logic [sfdc_pkg::WORD_W-1:0]        msg_id,
	output logic [sfdc_pkg::WORD_W-1:0]        msg_len
);

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEAD = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	logic [sfdc_pkg::BYTE_W-1:0] fsync_hi_q, fsync_lo_q, msync_hi_q, msync_lo_q;

	phase_t                      phase_q, phase_d;
	logic [sfdc_pkg::BYTE_W-1:0] prev_q;
	logic [sfdc_pkg::WORD_W-1:0] idx_q, idx_d;
	logic [sfdc_pkg::WORD_W-1:0] flen_q, flen_d;
	logic [sfdc_pkg::BYTE_W-1:0] hsum_q, hsum_d;
	logic [sfdc_pkg::BYTE_W-1:0] bsum_q, bsum_d;
	logic [sfdc_pkg::WORD_W-1:0] mlen_q, mlen_d;
	logic [sfdc_pkg::WORD_W-1:0] mid_q, mid_d;
	logic                        msync_ok_q, msync_ok_d;

	logic                        res_vld;
	sfdc_pkg::status_t           res_st;
	logic [sfdc_pkg::WORD_W-1:0] res_id, res_len;

	logic                        out_valid_q;
	sfdc_pkg::status_t           out_st_q;
	logic [sfdc_pkg::WORD_W-1:0] out_id_q, out_len_q;

	logic                        in_xfer;
	logic [sfdc_pkg::BYTE_W-1:0] trailer_want;

	// hold input while a finished status waits on a stalled receiver
	assign in_stall = out_valid_q & out_stall;
	assign in_xfer  = in_valid & ~in_stall;

	assign trailer_want = 8'd0 - bsum_q;

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		flen_d     = flen_q;
		hsum_d     = hsum_q;
		bsum_d     = bsum_q;
		mlen_d     = mlen_q;
		mid_d      = mid_q;
		msync_ok_d = msync_ok_q;
		res_vld    = 1'b0;
		res_st     = sfdc_pkg::ST_OK;
		res_id     = '0;
		res_len    = '0;

		case (phase_q)
			PH_HEAD: begin
				if (idx_q == 16'd2) begin
					flen_d = {data_byte, 8'd0};
					hsum_d = hsum_q + data_byte;
					idx_d  = 16'd3;
				end else if (idx_q == 16'd3) begin
					flen_d = {flen_q[15:8], data_byte};
					hsum_d = hsum_q + data_byte;
					idx_d  = 16'd4;
				end else if (data_byte != hsum_q) begin
					res_vld = 1'b1;
					res_st  = sfdc_pkg::ST_HDR_SUM;
					phase_d = PH_HUNT;
				end else if (flen_q < sfdc_pkg::MIN_FRAME_LEN) begin
					res_vld = 1'b1;
					res_st  = sfdc_pkg::ST_BUF_SHORT;
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_BODY;
					idx_d   = 16'd5;
				end
			end
			PH_BODY: begin
				if (idx_q < flen_q) begin
					bsum_d = bsum_q + data_byte;
					if (idx_q == 16'd5 && data_byte != msync_hi_q)
						msync_ok_d = 1'b0;
					if (idx_q == 16'd6 && data_byte != msync_lo_q)
						msync_ok_d = 1'b0;
					if (idx_q == 16'd7)
						mlen_d = {data_byte, 8'd0};
					if (idx_q == 16'd8)
						mlen_d = {mlen_q[15:8], data_byte};
					if (idx_q == 16'd9)
						mid_d = {data_byte, 8'd0};
					if (idx_q == 16'd10)
						mid_d = {mid_q[15:8], data_byte};
					idx_d = idx_q + 16'd1;
				end else begin
					// trailer byte: checks in priority order
					res_vld = 1'b1;
					res_len = mlen_q;
					phase_d = PH_HUNT;
					if (data_byte != trailer_want)
						res_st = sfdc_pkg::ST_TRAILER;
					else if (!msync_ok_q)
						res_st = sfdc_pkg::ST_MSG_SYNC;
					else if (mlen_q != flen_q - sfdc_pkg::MSG_LEN_OFFSET)
						res_st = sfdc_pkg::ST_LEN_MISM;
					else begin
						res_st = sfdc_pkg::ST_OK;
						res_id = mid_q;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (prev_q == fsync_hi_q && data_byte == fsync_lo_q) begin
					phase_d    = PH_HEAD;
					idx_d      = 16'd2;
					flen_d     = '0;
					hsum_d     = prev_q + data_byte;
					bsum_d     = '0;
					mlen_d     = '0;
					mid_d      = '0;
					msync_ok_d = 1'b1;
				end
			end
		endcase

		// chunk end: abandon an open frame or report no sync
		if (!res_vld && buffer_last) begin
			res_vld = 1'b1;
			res_st  = (phase_d != PH_HUNT) ? sfdc_pkg::ST_BUF_SHORT : sfdc_pkg::ST_NO_SYNC;
			phase_d = PH_HUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsync_hi_q <= '0;
			fsync_lo_q <= '0;
			msync_hi_q <= '0;
			msync_lo_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sfdc_pkg::REG_FRAME_SYNC_HIGH: fsync_hi_q <= cfg_data;
				sfdc_pkg::REG_FRAME_SYNC_LOW:  fsync_lo_q <= cfg_data;
				sfdc_pkg::REG_MSG_SYNC_HIGH:   msync_hi_q <= cfg_data;
				sfdc_pkg::REG_MSG_SYNC_LOW:    msync_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			prev_q     <= '0;
			idx_q      <= '0;
			flen_q     <= '0;
			hsum_q     <= '0;
			bsum_q     <= '0;
			mlen_q     <= '0;
			mid_q      <= '0;
			msync_ok_q <= 1'b0;
		end else if (in_xfer) begin
			phase_q    <= phase_d;
			prev_q     <= data_byte;
			idx_q      <= idx_d;
			flen_q     <= flen_d;
			hsum_q     <= hsum_d;
			bsum_q     <= bsum_d;
			mlen_q     <= mlen_d;
			mid_q      <= mid_d;
			msync_ok_q <= msync_ok_d;
		end
	end

	// output register: load on a transfer, drop once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= res_vld;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_st_q  <= sfdc_pkg::ST_OK;
			out_id_q  <= '0;
			out_len_q <= '0;
		end else if (in_xfer && res_vld) begin
			out_st_q  <= res_st;
			out_id_q  <= res_id;
			out_len_q <= res_len;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_st_q;
	assign msg_id    = out_id_q;
	assign msg_len   = out_len_q;

endmodule

`default_nettype wire

/* design/sfdc_checker.sv */
// ---------------------------------------------------------------------------
// sfdc_checker
// Port-level checks of the serial frame deframer and checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfdc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        buffer_last,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [2:0]                  status,
	input wire logic [sfdc_pkg::WORD_W-1:0] msg_id,
	input wire logic [sfdc_pkg::WORD_W-1:0] msg_len
);

	// a stalled status holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(msg_id) && $stable(msg_len))
		else $error("stalled status changed");

	// the last byte of a chunk always produces a status
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && buffer_last |=> out_valid)
		else $error("chunk end gave no status");

	// message id is reported only for a good frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != sfdc_pkg::ST_OK |-> msg_id == '0)
		else $error("message id on error status");

	// early errors and chunk-end statuses carry no message length
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sfdc_pkg::ST_HDR_SUM || status == sfdc_pkg::ST_BUF_SHORT
			|| status == sfdc_pkg::ST_NO_SYNC) |-> msg_len == '0)
		else $error("message length on early status");

endmodule

bind serial_frame_deframer_checker sfdc_checker u_sfdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.buffer_last (buffer_last),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.msg_id      (msg_id),
	.msg_len     (msg_len)
);

`default_nettype wire
